[rtl/inverse_cdf_table_sampler_macros.svh]
`ifndef INVERSE_CDF_TABLE_SAMPLER_MACROS_SVH
`define INVERSE_CDF_TABLE_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ICDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ICDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/icdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package icdf_pkg;

  localparam int TableDepthDef = 256;
  localparam int CfgResetVal   = 256;

  localparam int IdxW    = 8;
  localparam int CdfW    = 25;
  localparam int EnW     = 24;
  localparam int UniW    = 24;
  localparam int CfgW    = 9;
  localparam int StatW   = 2;
  localparam int InDataW = 88;   // 81 field bits padded to whole bytes
  localparam int InUserW = 1;
  localparam int OutDataW = 24;

  localparam int DivSteps = EnW; // quotient never exceeds the energy step
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_REDRAW = 2'd1,
    STAT_ABOVE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    wr_en;
    logic    start;
    logic    advance;
    logic    capture;
    logic    mul;
    logic    div_step;
    logic    out_load;
    status_e out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic redraw;
    logic hit;
    logic last;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/icdf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module icdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/icdf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module icdf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  input  wire logic               s_cmd_i,
  output logic                    s_ready_o,
  input  wire logic               m_ready_i,
  output logic                    m_valid_o,
  output icdf_pkg::dp_cmd_t       cmd_o,
  input  wire icdf_pkg::dp_stat_t stat_i
);

  icdf_pkg::state_e  state_q, state_d;
  icdf_pkg::status_e res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              accept;

  assign s_ready_o = (state_q == icdf_pkg::ST_IDLE);
  assign accept    = s_valid_i & s_ready_o;
  assign out_free  = ~out_valid_q | m_ready_i;
  assign m_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      icdf_pkg::ST_IDLE: begin
        if (accept && (s_cmd_i == icdf_pkg::CMD_SAMPLE)) begin
          state_d = icdf_pkg::ST_FIRST;
        end
      end
      icdf_pkg::ST_FIRST: begin
        state_d = stat_i.redraw ? icdf_pkg::ST_DONE : icdf_pkg::ST_SCAN;
      end
      icdf_pkg::ST_SCAN: begin
        if (stat_i.hit) begin
          state_d = icdf_pkg::ST_MUL;
        end else if (stat_i.last) begin
          state_d = icdf_pkg::ST_DONE;
        end
      end
      icdf_pkg::ST_MUL: state_d = icdf_pkg::ST_DIV;
      icdf_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = icdf_pkg::ST_DONE;
        end
      end
      icdf_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = icdf_pkg::ST_IDLE;
        end
      end
      default: state_d = icdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = res_q;
    res_d            = res_q;
    unique case (state_q)
      icdf_pkg::ST_IDLE: begin
        cmd_o.wr_en = accept & (s_cmd_i == icdf_pkg::CMD_LOAD);
        cmd_o.start = accept & (s_cmd_i == icdf_pkg::CMD_SAMPLE);
      end
      icdf_pkg::ST_FIRST: begin
        if (stat_i.redraw) begin
          res_d = icdf_pkg::STAT_REDRAW;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      icdf_pkg::ST_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.capture = 1'b1;
        end else begin
          cmd_o.advance = 1'b1;
          if (stat_i.last) begin
            res_d = icdf_pkg::STAT_ABOVE;
          end
        end
      end
      icdf_pkg::ST_MUL: cmd_o.mul = 1'b1;
      icdf_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          res_d = icdf_pkg::STAT_OK;
        end
      end
      icdf_pkg::ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= icdf_pkg::ST_IDLE;
      res_q       <= icdf_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/icdf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module icdf_dp #(
  parameter int TableDepth = icdf_pkg::TableDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire icdf_pkg::dp_cmd_t            cmd_i,
  output icdf_pkg::dp_stat_t                stat_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [icdf_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic [icdf_pkg::IdxW-1:0]    entry_index_i,
  input  wire logic [icdf_pkg::CdfW-1:0]    cdf_value_i,
  input  wire logic [icdf_pkg::EnW-1:0]     entry_energy_i,
  input  wire logic [icdf_pkg::UniW-1:0]    uniform_value_i,
  output logic      [icdf_pkg::EnW-1:0]     energy_o,
  output icdf_pkg::status_e                 status_o
);

  localparam int AddrW     = $clog2(TableDepth);
  localparam int CdfW      = icdf_pkg::CdfW;
  localparam int EnW       = icdf_pkg::EnW;
  localparam int RamW      = CdfW + EnW;
  localparam int ProdW     = EnW + CdfW;
  localparam int NumW      = ProdW + 1;
  localparam int ResetCnt  = (TableDepth < icdf_pkg::CfgResetVal) ? TableDepth
                                                                   : icdf_pkg::CfgResetVal;
  localparam logic [AddrW-1:0] ResetLast = AddrW'(ResetCnt - 1);
  localparam logic [AddrW-1:0] MaxLast   = AddrW'(TableDepth - 1);
  localparam logic [icdf_pkg::DivCntW-1:0] DivLast =
    icdf_pkg::DivCntW'(icdf_pkg::DivSteps - 1);

  // table storage: {energy, cdf}
  logic             ram_we;
  logic [AddrW-1:0] ram_raddr;
  logic [RamW-1:0]  ram_rdata;
  logic [CdfW-1:0]  rd_cdf;
  logic [EnW-1:0]   rd_en;

  logic [AddrW-1:0] last_idx_q, last_idx_d;
  logic [AddrW-1:0] cnt_q;
  logic [icdf_pkg::UniW-1:0] u_q;
  logic [CdfW-1:0]  u_ext;
  logic [CdfW-1:0]  prev_cdf_q;
  logic [EnW-1:0]   prev_en_q;

  logic [EnW-1:0]   ea_q;
  logic [EnW-1:0]   mag_q;
  logic             up_q;
  logic [CdfW-1:0]  t_q;
  logic [CdfW-1:0]  dx_q;

  logic [ProdW-1:0] prod;
  logic [NumW-1:0]  num;
  logic [CdfW-1:0]  rem_q;
  logic [EnW-1:0]   quo_q;
  logic [CdfW:0]    rem_sh;
  logic             q_bit;
  logic [icdf_pkg::DivCntW-1:0] div_cnt_q;
  logic [EnW-1:0]   result;

  assign ram_we    = cmd_i.wr_en & (32'(entry_index_i) < TableDepth);
  assign ram_raddr = cmd_i.start ? '0 : AddrW'(cnt_q + 1'b1);

  icdf_ram #(
    .Width (RamW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(entry_index_i)),
    .wdata_i ({entry_energy_i, cdf_value_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_cdf = ram_rdata[CdfW-1:0];
  assign rd_en  = ram_rdata[RamW-1:CdfW];
  assign u_ext  = {1'b0, u_q};

  assign stat_o.redraw   = (u_ext <= rd_cdf);
  assign stat_o.hit      = (rd_cdf >= u_ext);
  assign stat_o.last     = (cnt_q == last_idx_q);
  assign stat_o.div_done = (div_cnt_q == DivLast);

  // clamp entries_in_use to [2, depth], kept as index of the last entry
  always_comb begin
    if (cfg_data_i < icdf_pkg::CfgW'(2)) begin
      last_idx_d = AddrW'(1);
    end else if (32'(cfg_data_i) > TableDepth) begin
      last_idx_d = MaxLast;
    end else begin
      last_idx_d = AddrW'(cfg_data_i - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= ResetLast;
    end else if (cfg_we_i) begin
      last_idx_q <= last_idx_d;
    end
  end

  // scan: data for entry cnt_q arrives while entry cnt_q+1 is being read
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      u_q   <= uniform_value_i;
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      prev_cdf_q <= rd_cdf;
      prev_en_q  <= rd_en;
      cnt_q      <= AddrW'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ea_q  <= prev_en_q;
      up_q  <= (rd_en >= prev_en_q);
      mag_q <= (rd_en >= prev_en_q) ? (rd_en - prev_en_q) : (prev_en_q - rd_en);
      t_q   <= u_ext - prev_cdf_q;
      dx_q  <= rd_cdf - prev_cdf_q;
    end
  end

  // numerator = mag * t + dx/2; quotient fits EnW bits, so the top part
  // already sits below dx and seeds the remainder
  assign prod   = mag_q * t_q;
  assign num    = {1'b0, prod} + NumW'(dx_q[CdfW-1:1]);
  assign rem_sh = {rem_q, quo_q[EnW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dx_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q     <= num[NumW-2:EnW];
      quo_q     <= num[EnW-1:0];
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= q_bit ? CdfW'(rem_sh - {1'b0, dx_q}) : rem_sh[CdfW-1:0];
      quo_q     <= {quo_q[EnW-2:0], q_bit};
      div_cnt_q <= icdf_pkg::DivCntW'(div_cnt_q + 1'b1);
    end
  end

  assign result = up_q ? EnW'(ea_q + quo_q) : EnW'(ea_q - quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o <= cmd_i.out_status;
      energy_o <= (cmd_i.out_status == icdf_pkg::STAT_OK) ? result : '0;
    end
  end

endmodule

`default_nettype wire

[rtl/inverse_cdf_table_sampler.sv]
// Channel  | Dir | Signals                                 | Contents
// s_axis   | in  | tvalid, tready, tdata[87:0], tuser[0:0] | load entry or sample request
// m_axis   | out | tvalid, tready, tdata[23:0], tuser[1:0] | sampled energy and status
// cfg      | in  | cfg_valid, cfg_ready, cfg_data[8:0]     | entries_in_use
//
// A load writes its entry without leaving the idle state. A sample scans up to entry k,
// the first entry at or above the uniform value: one entry per cycle on the single table
// read port, then a multiply state and a 24-step divider. Redraw shows once entry 0 is read,
// above-table once the n entries in use are scanned; input is taken when the result loads.
// Reset clears only control state and entries_in_use (256, capped to the depth);
// the table is undefined until loaded. A finished result waits while the output is full.
`timescale 1ns / 1ps
`default_nettype none

module inverse_cdf_table_sampler #(
  parameter int TableDepth = icdf_pkg::TableDepthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] entry_index, [32:8] cdf_value, [56:33] entry_energy, [80:57] uniform_value
  input  wire logic [icdf_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] command
  input  wire logic [icdf_pkg::InUserW-1:0]    s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [23:0] sampled_energy
  output logic      [icdf_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // [1:0] status
  output logic      [icdf_pkg::StatW-1:0]      m_axis_tuser_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [icdf_pkg::CfgW-1:0]       cfg_data_i
);

  icdf_pkg::dp_cmd_t  cmd;
  icdf_pkg::dp_stat_t stat;
  icdf_pkg::status_e  status;

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tuser_o = status;

  icdf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_cmd_i   (s_axis_tuser_i[0]),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  icdf_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .entry_index_i   (s_axis_tdata_i[7:0]),
    .cdf_value_i     (s_axis_tdata_i[32:8]),
    .entry_energy_i  (s_axis_tdata_i[56:33]),
    .uniform_value_i (s_axis_tdata_i[80:57]),
    .energy_o        (m_axis_tdata_o),
    .status_o        (status)
  );

endmodule

`default_nettype wire

[rtl/icdf_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "inverse_cdf_table_sampler_macros.svh"

module icdf_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic [icdf_pkg::InUserW-1:0]  s_axis_tuser_i,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [icdf_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic [icdf_pkg::StatW-1:0]    m_axis_tuser_o
);

  logic load_acc;
  logic samp_acc;

  assign load_acc = s_axis_tvalid_i & s_axis_tready_o
                    & (s_axis_tuser_i[0] == icdf_pkg::CMD_LOAD);
  assign samp_acc = s_axis_tvalid_i & s_axis_tready_o
                    & (s_axis_tuser_i[0] == icdf_pkg::CMD_SAMPLE);

  `ICDF_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  `ICDF_ASSERT_NOW(a_zero_energy, m_axis_tvalid_o && (m_axis_tuser_o != icdf_pkg::STAT_OK), m_axis_tdata_o == '0, "nonzero energy on redraw or above-table")

  `ICDF_ASSERT_NEXT(a_load_no_result, load_acc, !$rose(m_axis_tvalid_o), "load transaction produced a result")

  `ICDF_ASSERT_NEXT(a_sample_busy, samp_acc, !s_axis_tready_o, "input taken during a sample")

endmodule

bind inverse_cdf_table_sampler icdf_chk u_icdf_chk (.*);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import icdf_pkg::*;

  localparam int PERIOD        = 12;
  localparam int DEPTH         = TableDepthDef;
  localparam int PadW          = InDataW - IdxW - CdfW - EnW - UniW;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int CDF_ONE       = 1 << 24;
  localparam int U_MAX         = CDF_ONE - 1;

  typedef struct packed {
    logic [EnW-1:0] energy;
    status_e        status;
  } draw_t;

  // Table mirror, entry count and the draws still owed by the block.
  class sampler_scoreboard;
    logic [CdfW-1:0] cdf_mem [DEPTH];
    logic [EnW-1:0]  energy_mem [DEPTH];
    bit              loaded [DEPTH];
    int              entries_cfg;
    draw_t           pending_draws [$];
    int              errors;

    function void clear();
      foreach (cdf_mem[i]) begin
        cdf_mem[i]    = '0;
        energy_mem[i] = '0;
        loaded[i]     = 1'b0;
      end
      entries_cfg = (CfgResetVal > DEPTH) ? DEPTH : CfgResetVal;
      pending_draws.delete();
      errors = 0;
    endfunction

    function int active_entries();
      if (entries_cfg < 2) return 2;
      if (entries_cfg > DEPTH) return DEPTH;
      return entries_cfg;
    endfunction

    // 0 means redraw, active_entries() means nothing reached u.
    function int first_reaching(logic [UniW-1:0] u);
      int n;
      n = active_entries();
      if ({1'b0, u} <= cdf_mem[0]) return 0;
      for (int i = 1; i < n; i++) begin
        if (cdf_mem[i] >= {1'b0, u}) return i;
      end
      return n;
    endfunction

    // True when the scan for u only touches entries already loaded.
    function bit sample_safe(logic [UniW-1:0] u);
      int last;
      last = first_reaching(u);
      if (last >= active_entries()) last = active_entries() - 1;
      for (int j = 0; j <= last; j++) begin
        if (!loaded[j]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Linear step from entry hi-1 toward entry hi, magnitude rounded half away.
    function logic [EnW-1:0] blend(int hi, logic [UniW-1:0] u);
      logic [63:0] e_lo, e_hi, c_lo, c_hi, uu, span, offset, gap, step, res;
      e_lo   = {40'd0, energy_mem[hi-1]};
      e_hi   = {40'd0, energy_mem[hi]};
      c_lo   = {39'd0, cdf_mem[hi-1]};
      c_hi   = {39'd0, cdf_mem[hi]};
      uu     = {40'd0, u};
      span   = c_hi - c_lo;
      offset = uu - c_lo;
      if (span == 64'd0) return e_hi[EnW-1:0];
      gap  = (e_hi >= e_lo) ? e_hi - e_lo : e_lo - e_hi;
      step = (gap * offset + span / 64'd2) / span;
      if (step > gap) step = gap;
      res = (e_hi >= e_lo) ? e_lo + step : e_lo - step;
      return res[EnW-1:0];
    endfunction

    function void accept_item(cmd_e cmd, logic [IdxW-1:0] idx, logic [CdfW-1:0] cdf,
                              logic [EnW-1:0] en, logic [UniW-1:0] u);
      draw_t want;
      int    hit;
      if (cmd == CMD_LOAD) begin
        if (int'(idx) < DEPTH) begin
          cdf_mem[idx]    = cdf;
          energy_mem[idx] = en;
          loaded[idx]     = 1'b1;
        end
        return;
      end
      hit = first_reaching(u);
      want.energy = '0;
      if (hit == 0) begin
        want.status = STAT_REDRAW;
      end else if (hit >= active_entries()) begin
        want.status = STAT_ABOVE;
      end else begin
        want.status = STAT_OK;
        want.energy = blend(hit, u);
      end
      pending_draws.insert(pending_draws.size(), want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_draw(logic [EnW-1:0] en, logic [StatW-1:0] st);
      draw_t want;
      if (pending_draws.size() == 0) begin
        report($sformatf("unexpected result energy=%0d status=%0d", en, st));
        return;
      end
      want = pending_draws.pop_front();
      if (st !== want.status)
        report($sformatf("status got %0d want %0d", st, want.status));
      if (en !== want.energy)
        report($sformatf("energy got %0d want %0d", en, want.energy));
    endtask
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic [InUserW-1:0]  s_tuser   = '0;
  logic                m_tready  = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgW-1:0]     cfg_data  = '0;
  wire                 s_tready;
  wire                 m_tvalid;
  wire [OutDataW-1:0]  m_tdata;
  wire [StatW-1:0]     m_tuser;
  wire                 cfg_ready;

  sampler_scoreboard sb;
  int send_left  = 0;
  int recv_left  = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int idle_run   = 0;
  int phase_entries [12] = '{256, 0, 16, 511, 1, 64, 257, 2, 255, 3, 128, 40};

  inverse_cdf_table_sampler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // Wait drawn per transaction; runs of draws with no wait at all now and then.
  function automatic int draw_wait(inout int left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(20, 60);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // Any transaction on any channel resets the stall counter.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tready && m_tvalid) begin
        sb.check_draw(m_tdata, m_tuser);
        stall = draw_wait(recv_left, recv_quiet);
        if (stall != 0) m_tready <= 1'b0;
      end else if (!m_tready) begin
        if (stall != 0) stall--;
        if (stall == 0) m_tready <= 1'b1;
      end
    end
  end

  // tvalid stays high into the next item when no gap is drawn.
  task automatic send_item(cmd_e cmd, logic [IdxW-1:0] idx, logic [CdfW-1:0] cdf,
                           logic [EnW-1:0] en, logic [UniW-1:0] u);
    int gap;
    gap = draw_wait(send_left, send_quiet);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{PadW{1'b0}}, u, en, cdf, idx};
    do @(posedge clk_i); while (!s_tready);
    sb.accept_item(cmd, idx, cdf, en, u);
  endtask

  task automatic load_entry(int idx, int cdf, logic [EnW-1:0] en);
    logic [31:0] r;
    r = $urandom;
    send_item(CMD_LOAD, idx[IdxW-1:0], cdf[CdfW-1:0], en, r[UniW-1:0]);
  endtask

  task automatic draw_sample(logic [UniW-1:0] u);
    logic [31:0] r1, r2;
    r1 = $urandom;
    r2 = $urandom;
    send_item(CMD_SAMPLE, r1[IdxW-1:0], {1'b0, r2[EnW-1:0]}, r1[31:8], u);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_draws.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entries(int count);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= count[CfgW-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.entries_cfg = count;
  endtask

  // Rising cumulative values that end near one, sometimes clipped at one.
  task automatic load_ramp(int m);
    int          level, stride;
    logic [31:0] r;
    stride = (1 << 25) / m;
    level  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, CDF_ONE / (4 * m));
    for (int i = 0; i < m; i++) begin
      r = $urandom;
      load_entry(i, level, r[EnW-1:0]);
      level = level + int'($urandom_range(0, stride));
      if (level > CDF_ONE) level = CDF_ONE;
    end
  endtask

  task automatic random_item();
    int          n, j, pick, u, lo, hi;
    logic [31:0] r;
    n    = sb.active_entries();
    pick = $urandom_range(0, 99);
    r    = $urandom;
    if (pick < 70) begin
      if (pick < 35) begin
        u = {8'd0, r[UniW-1:0]};
      end else begin
        // land on, just below or just above a stored boundary
        j = $urandom_range(0, n - 1);
        u = {7'd0, sb.cdf_mem[j]};
        u = u + int'($urandom_range(0, 2)) - 1;
        if (u < 0) u = 0;
        if (u > U_MAX) u = U_MAX;
      end
      if (sb.sample_safe(u[UniW-1:0])) begin
        draw_sample(u[UniW-1:0]);
        return;
      end
    end
    if (pick < 85) begin
      j  = $urandom_range(0, n - 1);
      lo = (j == 0) ? 0 : {7'd0, sb.cdf_mem[j-1]};
      hi = (j == n - 1) ? CDF_ONE : {7'd0, sb.cdf_mem[j+1]};
      load_entry(j, $urandom_range(lo, hi), r[EnW-1:0]);
    end else begin
      load_entry($urandom_range(0, DEPTH - 1), $urandom_range(0, CDF_ONE), r[EnW-1:0]);
    end
  endtask

  initial begin : stimulus
    int n;
    sb = new;
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_entries(4);
    load_entry(0, 1000, 24'd100);
    load_entry(1, 24'h40_0000, 24'hFF_FFFF);
    load_entry(2, 24'h80_0000, 24'd0);
    load_entry(3, 24'hC0_0000, 24'd0);
    draw_sample(24'd0);
    draw_sample(24'd1000);          // tie with the first entry still redraws
    draw_sample(24'd1001);
    draw_sample(24'h40_0000);       // exact hit on an entry
    draw_sample(24'h60_0000);       // falling energy
    draw_sample(24'hA0_0000);       // flat energy
    draw_sample(24'hC0_0001);       // past the last entry in use
    load_entry(3, CDF_ONE, 24'h12_3456);
    draw_sample(24'hFF_FFFF);
    load_entry(255, CDF_ONE, 24'hFF_FFFF);
    load_entry(0, 10, 24'd5);
    load_entry(1, 12, 24'd6);
    load_entry(2, 14, 24'd5);
    draw_sample(24'd11);            // half-way rounds away from the lower entry
    draw_sample(24'd13);
    load_entry(0, 0, 24'd0);
    draw_sample(24'd0);
    draw_sample(24'd1);

    foreach (phase_entries[p]) begin
      write_entries(phase_entries[p]);
      n = sb.active_entries();
      load_ramp((p == 0) ? DEPTH : ((n < 48) ? n : 48));
      repeat (80) random_item();
    end

    settle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
